### hw/rtl/assert_macros.svh
// Assertion macros shared by the heightmap normal RTL.
// Depends on nothing; files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, checked on every rising edge outside reset.
`define HNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication.
`define HNS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define HNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HNS_ASSERT(lbl, prop, msg)
`define HNS_ASSERT_IMPL(lbl, ante, cons, msg)
`define HNS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/hns_pkg.sv
// Shared types and constants of the heightmap normal and slope block.
// Depends on nothing.
package hns_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 256;
  localparam int BUF_DEPTH   = MAX_COLS + 2;
  localparam int BUF_AW      = $clog2(BUF_DEPTH);
  localparam int CNT_W       = 9;
  localparam int HEIGHT_BITS = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_VERTEX_COLS = 2'd0;
  localparam logic [1:0] REG_VERTEX_ROWS = 2'd1;
  localparam logic [1:0] REG_UNIT_SIZE   = 2'd2;
  localparam logic [1:0] REG_AMPLITUDE   = 2'd3;

  // Vertex position and flags carried down the arithmetic pipeline.
  typedef struct packed {
    logic       dx_neg;
    logic       dy_neg;
    logic [7:0] col;
    logic [7:0] row;
    logic       last;
  } hns_tag_t;

  // One vertex handed from the stencil to the normal pipeline.
  typedef struct packed {
    logic                     valid;
    hns_tag_t                 tag;
    logic [HEIGHT_BITS-1:0]   dx_mag;
    logic [HEIGHT_BITS-1:0]   dy_mag;
  } hns_vtx_t;

endpackage

### hw/rtl/hns_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module hns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 258,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hw/rtl/hns_stencil.sv
// Raster counters, line buffer RAM and 3x3 stencil fetch.
// Depends on hns_pkg, hns_ram and assert_macros.svh.
`include "assert_macros.svh"
module hns_stencil import hns_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [HEIGHT_BITS-1:0] height_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   en_i,
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       vertex_cols_i,
  input  logic [CNT_W-1:0]       vertex_rows_i,
  output hns_vtx_t               vtx_o
);

  logic [CNT_W-1:0] cols, rows, ec, er;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0] cn, rn, rn0, c1, rd_a, rd_b1, rd_b;
  logic             wrap, accept, hit, pf_ok_q;
  logic             vtx_valid_q;
  logic [2*HEIGHT_BITS-1:0] rdata_a, rdata_b, wdata;
  logic [HEIGHT_BITS-1:0]   left_q, down, right;
  logic signed [HEIGHT_BITS:0] dx, dy;
  hns_vtx_t vtx_q, vtx_d;

  // Clamp the configured size to its working range.
  always_comb begin
    cols = vertex_cols_i;
    if (vertex_cols_i < CNT_W'(2)) cols = CNT_W'(2);
    if (vertex_cols_i > CNT_W'(MAX_COLS)) cols = CNT_W'(MAX_COLS);
    rows = vertex_rows_i;
    if (vertex_rows_i < CNT_W'(2)) rows = CNT_W'(2);
    if (vertex_rows_i > CNT_W'(MAX_ROWS)) rows = CNT_W'(MAX_ROWS);
    ec = cols + CNT_W'(2);
    er = rows + CNT_W'(2);
  end

  // Position of the sample now on offer, with wrap after a shrunk grid.
  always_comb begin
    wrap = (col_q >= ec);
    cn   = wrap ? '0 : col_q;
    rn0  = wrap ? row_q + CNT_W'(1) : row_q;
    rn   = (rn0 >= er) ? '0 : rn0;
    c1   = cn + CNT_W'(1);
  end

  // The prefetched buffer words are good only if no register changed under them.
  assign in_stall_o = !(en_i && pf_ok_q);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (c1 >= ec) begin
        col_d = '0;
        row_d = (rn + CNT_W'(1) >= er) ? '0 : rn + CNT_W'(1);
      end else begin
        col_d = c1;
        row_d = rn;
      end
    end
  end

  // Read ahead the column about to be offered and the one to its right.
  always_comb begin
    rd_a  = (col_d >= ec) ? '0 : col_d;
    rd_b1 = rd_a + CNT_W'(1);
    rd_b  = (rd_b1 >= ec) ? '0 : rd_b1;
  end

  // Each word holds {two rows back, one row back} for one column.
  assign wdata = {rdata_a[HEIGHT_BITS-1:0], height_i};

  hns_ram #(
    .WIDTH (2*HEIGHT_BITS),
    .DEPTH (BUF_DEPTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (cn[BUF_AW-1:0]),
    .wdata_i   (wdata),
    .raddr_a_i (rd_a[BUF_AW-1:0]),
    .raddr_b_i (rd_b[BUF_AW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Stencil differences for the vertex one row above the current sample.
  always_comb begin
    down  = rdata_a[2*HEIGHT_BITS-1:HEIGHT_BITS];
    right = rdata_b[HEIGHT_BITS-1:0];
    dx    = $signed({left_q[HEIGHT_BITS-1], left_q}) - $signed({right[HEIGHT_BITS-1], right});
    dy    = $signed({down[HEIGHT_BITS-1], down}) - $signed({height_i[HEIGHT_BITS-1], height_i});
    hit   = (rn >= CNT_W'(2)) && (cn >= CNT_W'(1)) && (cn <= cols);
    vtx_d.valid      = accept && hit;
    vtx_d.tag.dx_neg = dx[HEIGHT_BITS];
    vtx_d.tag.dy_neg = dy[HEIGHT_BITS];
    vtx_d.tag.col    = 8'(cn - CNT_W'(1));
    vtx_d.tag.row    = 8'(rn - CNT_W'(2));
    vtx_d.tag.last   = (cn == cols) && (rn == rows + CNT_W'(1));
    vtx_d.dx_mag     = dx[HEIGHT_BITS] ? HEIGHT_BITS'(-dx) : dx[HEIGHT_BITS-1:0];
    vtx_d.dy_mag     = dy[HEIGHT_BITS] ? HEIGHT_BITS'(-dy) : dy[HEIGHT_BITS-1:0];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      pf_ok_q     <= 1'b0;
      vtx_valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      pf_ok_q <= !cfg_we_i;
      if (en_i) begin
        vtx_valid_q <= vtx_d.valid;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q <= rdata_a[HEIGHT_BITS-1:0];
    end
    if (en_i) begin
      vtx_q <= vtx_d;
    end
  end

  assign vtx_o = '{valid: vtx_valid_q, tag: vtx_q.tag, dx_mag: vtx_q.dx_mag,
                   dy_mag: vtx_q.dy_mag};

  `HNS_ASSERT_NEXT(a_cfg_blocks_sample, cfg_we_i, in_stall_o, "sample taken on stale prefetch")
  `HNS_ASSERT_IMPL(a_no_rw_clash, accept, (cn != rd_a) && (cn != rd_b), "buffer clash")
  `HNS_ASSERT(a_col_in_grid, cn < ec, "column beyond grid")

endmodule

### hw/rtl/hns_normal.sv
// Normal vector pipeline: scale, square, root, three dividers and slope.
// Depends on hns_pkg.
module hns_normal import hns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  hns_vtx_t         vtx_i,
  input  logic [15:0]      unit_size_i,
  input  logic [15:0]      amplitude_i,
  output logic             valid_o,
  output logic [7:0]       vertex_col_o,
  output logic [7:0]       vertex_row_o,
  output logic [15:0]      normal_x_o,
  output logic [15:0]      normal_y_o,
  output logic [14:0]      normal_z_o,
  output logic [7:0]       slope_o,
  output logic             last_o
);

  localparam int SQ = 32;
  localparam int DQ = 15;

  typedef struct packed {
    hns_tag_t    tag;
    logic [30:0] mx;
    logic [30:0] my;
    logic [30:0] mz;
  } mag_t;

  // Stage A: scale by amplitude.
  logic        a_v;
  hns_tag_t    a_tag;
  logic [31:0] a_x, a_y;
  logic [29:0] a_z;
  // Stage B: common right shift.
  logic        b_v, b_sh;
  mag_t        b_m;
  // Stage C: squares.
  logic        c_v;
  mag_t        c_m;
  logic [61:0] c_x2, c_y2, c_z2;
  // Root pipeline.
  logic        sq_v [SQ+1];
  mag_t        sq_m [SQ+1];
  logic [63:0] sq_n [SQ+1];
  logic [63:0] sq_r [SQ+1];
  // Division pipeline.
  logic        dv_v [DQ+1];
  hns_tag_t    dv_t [DQ+1];
  logic        dv_z [DQ+1];
  logic [31:0] dv_l [DQ+1];
  logic [46:0] dv_rm [DQ+1][3];
  logic [14:0] dv_q  [DQ+1][3];
  // Output stage.
  logic        o_v_q;
  hns_tag_t    o_t_q;
  logic [15:0] o_x_q, o_y_q;
  logic [14:0] o_z_q;
  logic [7:0]  o_s_q;
  logic [14:0] nz, sl_full;
  logic [31:0] len;

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v      <= 1'b0;
      b_v      <= 1'b0;
      c_v      <= 1'b0;
      sq_v[0]  <= 1'b0;
      dv_v[0]  <= 1'b0;
      o_v_q    <= 1'b0;
    end else if (en_i) begin
      a_v      <= vtx_i.valid;
      b_v      <= a_v;
      c_v      <= b_v;
      sq_v[0]  <= c_v;
      dv_v[0]  <= sq_v[SQ];
      o_v_q    <= dv_v[DQ];
    end
  end

  // Front stages: products, normalising shift, squares, sum.
  assign b_sh = a_x[31] | a_y[31];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_tag    <= vtx_i.tag;
      a_x      <= vtx_i.dx_mag * amplitude_i;
      a_y      <= vtx_i.dy_mag * amplitude_i;
      a_z      <= {unit_size_i, 14'b0};
      b_m.tag  <= a_tag;
      b_m.mx   <= b_sh ? a_x[31:1] : a_x[30:0];
      b_m.my   <= b_sh ? a_y[31:1] : a_y[30:0];
      b_m.mz   <= b_sh ? {2'b0, a_z[29:1]} : {1'b0, a_z};
      c_m      <= b_m;
      c_x2     <= b_m.mx * b_m.mx;
      c_y2     <= b_m.my * b_m.my;
      c_z2     <= b_m.mz * b_m.mz;
      sq_m[0]  <= c_m;
      sq_n[0]  <= {2'b0, c_x2} + {2'b0, c_y2} + {2'b0, c_z2};
      sq_r[0]  <= '0;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [63:0] bit_w, trial;
    logic        ge;
    assign bit_w = 64'd1 << (2 * (SQ - 1 - j));
    assign trial = sq_r[j] + bit_w;
    assign ge    = sq_n[j] >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v[j+1] <= 1'b0;
      end else if (en_i) begin
        sq_v[j+1] <= sq_v[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_m[j+1] <= sq_m[j];
        sq_n[j+1] <= ge ? sq_n[j] - trial : sq_n[j];
        sq_r[j+1] <= ge ? (sq_r[j] >> 1) + bit_w : sq_r[j] >> 1;
      end
    end
  end

  // Rounded numerators for the three quotients.
  assign len = sq_r[SQ][31:0];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_t[0]     <= sq_m[SQ].tag;
      dv_z[0]     <= (len == '0);
      dv_l[0]     <= len;
      dv_rm[0][0] <= {2'b0, sq_m[SQ].mx, 14'b0} + 47'(len >> 1);
      dv_rm[0][1] <= {2'b0, sq_m[SQ].my, 14'b0} + 47'(len >> 1);
      dv_rm[0][2] <= {2'b0, sq_m[SQ].mz, 14'b0} + 47'(len >> 1);
      dv_q[0][0]  <= '0;
      dv_q[0][1]  <= '0;
      dv_q[0][2]  <= '0;
    end
  end

  // Restoring division, one quotient bit per stage for each component.
  for (genvar j = 0; j < DQ; j++) begin : g_div
    logic [46:0] dsh;
    assign dsh = {15'b0, dv_l[j]} << (DQ - 1 - j);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_v[j+1] <= dv_v[j];
      end
    end
    for (genvar k = 0; k < 3; k++) begin : g_comp
      logic ge;
      assign ge = dv_rm[j][k] >= dsh;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dv_rm[j+1][k] <= ge ? dv_rm[j][k] - dsh : dv_rm[j][k];
          dv_q[j+1][k]  <= {dv_q[j][k][13:0], ge};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_t[j+1] <= dv_t[j];
        dv_z[j+1] <= dv_z[j];
        dv_l[j+1] <= dv_l[j];
      end
    end
  end

  // Signs, zero-length case and the slope byte.
  assign nz      = dv_z[DQ] ? '0 : dv_q[DQ][2];
  assign sl_full = 15'd16416 - nz;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_t_q <= dv_t[DQ];
      o_x_q <= dv_z[DQ] ? '0 : (dv_t[DQ].dx_neg ? 16'(-{1'b0, dv_q[DQ][0]})
                                                : {1'b0, dv_q[DQ][0]});
      o_y_q <= dv_z[DQ] ? '0 : (dv_t[DQ].dy_neg ? 16'(-{1'b0, dv_q[DQ][1]})
                                                : {1'b0, dv_q[DQ][1]});
      o_z_q <= nz;
      o_s_q <= sl_full[14] ? 8'hFF : sl_full[13:6];
    end
  end

  assign valid_o      = o_v_q;
  assign vertex_col_o = o_t_q.col;
  assign vertex_row_o = o_t_q.row;
  assign normal_x_o   = o_x_q;
  assign normal_y_o   = o_y_q;
  assign normal_z_o   = o_z_q;
  assign slope_o      = o_s_q;
  assign last_o       = o_t_q.last;

endmodule

### hw/rtl/heightmap_normal_slope_top.sv
// Heightmap normal and slope unit, one border-extended sample per clock.
// It takes a sample on every cycle in which neither an output transfer is
// held nor the cycle just after a register write or reset; the line buffers
// sit in one dual-read RAM whose read-ahead of the next two columns sets that
// pause. Each interior vertex is formed when the sample below it is taken and passes
// through a 32-stage square root and three 15-stage dividers, and the whole
// pipeline holds while a result waits at the output.
// Depends on hns_pkg, hns_stencil and hns_normal.
module heightmap_normal_slope_top import hns_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [15:0]     height_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             vertex_col_o,
  output logic [7:0]             vertex_row_o,
  output logic signed [15:0]     normal_x_o,
  output logic signed [15:0]     normal_y_o,
  output logic [14:0]            normal_z_o,
  output logic [7:0]             slope_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i
);

  logic [CNT_W-1:0] cols_q, rows_q;
  logic [15:0]      unit_q, amp_q;
  logic             cfg_we, en;
  logic [15:0]      nx, ny;
  hns_vtx_t         vtx;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CNT_W'(64);
      rows_q <= CNT_W'(64);
      unit_q <= 16'd100;
      amp_q  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_VERTEX_COLS: cols_q <= cfg_data_i[CNT_W-1:0];
        REG_VERTEX_ROWS: rows_q <= cfg_data_i[CNT_W-1:0];
        REG_UNIT_SIZE:   unit_q <= cfg_data_i;
        REG_AMPLITUDE:   amp_q  <= cfg_data_i;
        default:         cols_q <= cols_q;
      endcase
    end
  end

  // The pipeline moves unless a result waits on a held output transfer.
  assign en = !(out_valid_o && out_stall_i);

  hns_stencil u_stencil (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .height_i      (height_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .en_i          (en),
    .cfg_we_i      (cfg_we),
    .vertex_cols_i (cols_q),
    .vertex_rows_i (rows_q),
    .vtx_o         (vtx)
  );

  hns_normal u_normal (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vtx_i        (vtx),
    .unit_size_i  (unit_q),
    .amplitude_i  (amp_q),
    .valid_o      (out_valid_o),
    .vertex_col_o (vertex_col_o),
    .vertex_row_o (vertex_row_o),
    .normal_x_o   (nx),
    .normal_y_o   (ny),
    .normal_z_o   (normal_z_o),
    .slope_o      (slope_o),
    .last_o       (last_o)
  );

  assign normal_x_o = $signed(nx);
  assign normal_y_o = $signed(ny);

endmodule

### tb/tb_top.sv
// Self-checking testbench of heightmap_normal_slope_top: whole tiles of samples with
// random and directed heights, a scoreboard that predicts each vertex normal and slope.
// Depends on hns_pkg and the heightmap_normal_slope_top RTL.
`timescale 1ns / 1ps

module tb_top;
  import hns_pkg::*;

  // One vertex result as seen on the output port.
  typedef struct packed {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [14:0] nz;
    logic [7:0]  slope;
    logic        last;
  } vertex_t;

  // Predicts the normal of each interior vertex and checks results in order.
  class normal_scoreboard;
    logic [8:0]  cols_reg = 9'd64;
    logic [8:0]  rows_reg = 9'd64;
    logic [15:0] unit_reg = 16'd100;
    logic [15:0] amp_reg  = 16'd1000;
    longint      row_two [MAX_COLS+2];
    longint      row_one [MAX_COLS+2];
    int unsigned col_cnt = 0;
    int unsigned row_cnt = 0;
    vertex_t     pending_q[$];
    int          errors = 0;
    int          checked = 0;
    int          samples = 0;

    function new();
      foreach (row_two[i]) begin
        row_two[i] = 0;
        row_one[i] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_VERTEX_COLS: cols_reg = data[8:0];
        REG_VERTEX_ROWS: rows_reg = data[8:0];
        REG_UNIT_SIZE:   unit_reg = data;
        default:         amp_reg  = data;
      endcase
    endfunction

    function int unsigned eff_cols();
      int unsigned c;
      c = cols_reg;
      if (c < 2) c = 2;
      if (c > MAX_COLS) c = MAX_COLS;
      return c;
    endfunction

    function int unsigned eff_rows();
      int unsigned r;
      r = rows_reg;
      if (r < 2) r = 2;
      if (r > 256) r = 256;
      return r;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint unsigned to_q14(longint unsigned mag, bit neg, longint unsigned len);
      longint unsigned q;
      q = (mag * 16384 + (len >> 1)) / len;
      return neg ? (64'd0 - q) : q;
    endfunction

    // Note an accepted sample, and queue the vertex it completes, if any.
    function void accept_sample(logic signed [15:0] h);
      int unsigned cols, rows, c, r, sh;
      longint dx, dy, hv;
      longint unsigned ax, ay, az, m, len, nx, ny, nz, sl;
      vertex_t e;
      cols = eff_cols();
      rows = eff_rows();
      hv = h;
      samples++;
      if (col_cnt >= cols + 2) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= rows + 2) row_cnt = 0;
      c = col_cnt;
      r = row_cnt;
      if (r >= 2 && c >= 1 && c <= cols) begin
        dx = row_two[c-1] - row_one[c+1];
        dy = row_two[c] - hv;
        ax = (dx < 0 ? -dx : dx) * amp_reg;
        ay = (dy < 0 ? -dy : dy) * amp_reg;
        az = (longint'(unit_reg) * 2) << 13;
        m = ax;
        if (ay > m) m = ay;
        if (az > m) m = az;
        sh = 0;
        while ((m >> sh) >= (64'd1 << 31)) sh++;
        ax >>= sh;
        ay >>= sh;
        az >>= sh;
        len = int_sqrt(ax * ax + ay * ay + az * az);
        if (len == 0) begin
          nx = 0;
          ny = 0;
          nz = 0;
        end else begin
          nx = to_q14(ax, dx < 0, len);
          ny = to_q14(ay, dy < 0, len);
          nz = to_q14(az, 1'b0, len);
        end
        sl = (64'd16384 - nz + 32) >> 6;
        if (sl > 255) sl = 255;
        e.col   = 8'(c - 1);
        e.row   = 8'(r - 2);
        e.nx    = nx[15:0];
        e.ny    = ny[15:0];
        e.nz    = nz[14:0];
        e.slope = sl[7:0];
        e.last  = (c == cols && r == rows + 1);
        pending_q.push_back(e);
      end
      row_two[c] = row_one[c];
      row_one[c] = hv;
      c++;
      if (c >= cols + 2) begin
        c = 0;
        r++;
        if (r >= rows + 2) r = 0;
      end
      col_cnt = c;
      row_cnt = r;
    endfunction

    // Compare one output transfer with the oldest expected vertex.
    function void check_vertex(vertex_t act);
      vertex_t exp_v;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected vertex col %0d row %0d", act.col, act.row);
        return;
      end
      exp_v = pending_q.pop_front();
      if (exp_v != act) begin
        errors++;
        if (errors <= 10)
          $display({"Mismatch: exp c%0d r%0d n(%0d,%0d,%0d) s%0d l%0b, ",
                    "got c%0d r%0d n(%0d,%0d,%0d) s%0d l%0b"},
                   exp_v.col, exp_v.row, $signed(exp_v.nx), $signed(exp_v.ny), exp_v.nz,
                   exp_v.slope, exp_v.last, act.col, act.row, $signed(act.nx),
                   $signed(act.ny), act.nz, act.slope, act.last);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] height_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         vertex_col_o, vertex_row_o, slope_o;
  logic signed [15:0] normal_x_o, normal_y_o;
  logic [14:0]        normal_z_o;
  logic               last_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = REG_VERTEX_COLS;
  logic [15:0]        cfg_data_i = '0;

  normal_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int tiles = 0;

  heightmap_normal_slope_top uut (.*);

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check every output transfer.
  always @(posedge clk_i) begin
    vertex_t act;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act.col   = vertex_col_o;
      act.row   = vertex_row_o;
      act.nx    = normal_x_o;
      act.ny    = normal_y_o;
      act.nz    = normal_z_o;
      act.slope = slope_o;
      act.last  = last_o;
      sb.check_vertex(act);
    end
  end

  // Register write through the configuration channel; the block must be idle.
  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offer one sample, idling first at random, and note it once transferred.
  task automatic send_sample(logic signed [15:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    height_i   = h;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.accept_sample(h);
    @(negedge clk_i);
  endtask

  // Wait until every expected vertex has left, then let the pipeline drain.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_tile(logic [15:0] cols, logic [15:0] rows, logic [15:0] unit_v,
                          logic [15:0] amp_v);
    write_cfg(REG_VERTEX_COLS, cols);
    write_cfg(REG_VERTEX_ROWS, rows);
    write_cfg(REG_UNIT_SIZE, unit_v);
    write_cfg(REG_AMPLITUDE, amp_v);
  endtask

  // One whole extended tile. Style 0: full-range noise, 1: gentle slope,
  // 2: flat ground, 3: alternating extremes.
  task automatic send_tile(int style);
    int unsigned ec, er;
    logic signed [15:0] h, base;
    ec = sb.eff_cols() + 2;
    er = sb.eff_rows() + 2;
    base = 16'($urandom);
    for (int r = 0; r < er; r++) begin
      for (int c = 0; c < ec; c++) begin
        case (style)
          0: h = 16'($urandom);
          1: h = base + 16'(r * 37) - 16'(c * 53) + 16'($urandom_range(63));
          2: h = 16'sd0;
          default: h = ((r + c) % 2) ? 16'sh7FFF : 16'sh8000;
        endcase
        send_sample(h);
      end
    end
    tiles++;
    drain();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: smallest tile at extreme heights and scales, zero length, clamping.
    set_tile(16'd2, 16'd2, 16'd1, 16'hFFFF);
    send_tile(3);
    set_tile(16'd2, 16'd2, 16'hFFFF, 16'd0);
    send_tile(0);
    set_tile(16'd1, 16'd0, 16'd0, 16'd1000);
    send_tile(2);

    // Random tiles over the idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 20 : 0;
      recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 20 : 0;
      while (sb.samples < 110 * (ph + 1) + 48) begin
        set_tile(16'($urandom_range(2, 8)), 16'($urandom_range(2, 6)),
                 ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535)),
                 ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom));
        send_tile($urandom_range(9) < 4 ? 0 : $urandom_range(9) < 8 ? 1 : 3);
      end
    end

    // Wide tile under a long output hold-off, then a tall narrow tile.
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    set_tile(16'd60, 16'd4, 16'd300, 16'd5000);
    hold_left = 300;
    send_tile(1);
    set_tile(16'd2, 16'd30, 16'd50, 16'd20000);
    send_tile(0);

    $display("Covered %0d samples in %0d tiles, %0d vertices checked, wide and tall tiles",
             sb.samples, tiles, sb.checked);
    $display("with idle, stall and hold-off phases, zero-length normals and register clamping.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d vertices missing", sb.errors, sb.pending_q.size());
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("Timeout with %0d vertices outstanding", sb.pending_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
